[hdl/imh_pkg.sv]
// Shared types and constants of the indexed max-heap unit.
package imh_pkg;

    localparam int VERTEX_BITS    = 10;
    localparam int VERTEX_SPACE   = 1 << VERTEX_BITS;
    localparam int MODE_BITS      = 2;
    localparam int IN_KEY_BITS    = 32;
    localparam int OUT_KEY_BITS   = 32;
    localparam int COUNT_OUT_BITS = 11;
    localparam int STATUS_BITS    = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_INSERT      = 2'd0,
        MODE_REMOVE_MAX  = 2'd1,
        MODE_REMOVE_VTX  = 2'd2,
        MODE_PEEK        = 2'd3
    } imh_mode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK      = 3'd0,
        STATUS_EMPTY   = 3'd1,
        STATUS_FULL    = 3'd2,
        STATUS_ABSENT  = 3'd3,
        STATUS_PRESENT = 3'd4
    } imh_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_TAIL,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_PLACE,
        ST_FINISH
    } imh_state_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]          mode;
        logic [VERTEX_BITS-1:0]        vertex;
        logic signed [IN_KEY_BITS-1:0] key;
    } imh_in_t;

    typedef struct packed {
        logic [VERTEX_BITS-1:0]         out_vertex;
        logic signed [OUT_KEY_BITS-1:0] out_key;
        logic [COUNT_OUT_BITS-1:0]      count_after;
        logic [STATUS_BITS-1:0]         status;
    } imh_out_t;

endpackage

[hdl/imh_stream_if.sv]
// Valid/ready stream channel used for the operation and result ports.
interface imh_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/indexed_max_heap_unit.sv]
// Indexed binary max-heap of vertex ids with a position map and a presence bitmap.
// A peek or a rejected operation goes straight from the check to the result; an insert climbs
// level by level from the new last slot; a removal moves the last entry into the hole, then
// climbs or descends level by level. All compares share one comparator. One operation at a
// time: input is taken only in the idle state, once the result is valid. Reset (rst_n low,
// asynchronous) empties the heap; a pass over all 1024 vertex ids clears the bitmap.
module indexed_max_heap_unit
    import imh_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    imh_stream_if.sink   item,
    imh_stream_if.source result
);

    // Slot index and entry count widths follow from the capacity.
    localparam int SB = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CB = $clog2(CAPACITY + 1);

    // Heap slots: vertex id and key, one read and one write port each cycle.
    logic [VERTEX_BITS-1:0] slot_v_mem [CAPACITY];
    logic [KEY_BITS-1:0]    slot_k_mem [CAPACITY];
    // Position map and presence bitmap, both addressed by vertex id.
    logic [SB-1:0]          vslot_mem  [VERTEX_SPACE];
    logic                   present_mem[VERTEX_SPACE];

    imh_state_t state_reg, state_next;

    logic [CB-1:0]          cnt_reg, cnt_next;
    logic [SB-1:0]          pos_reg, pos_next;
    logic [SB-1:0]          tgt_pos_reg, tgt_pos_next;
    logic [SB-1:0]          child_pos_reg, child_pos_next;
    logic [MODE_BITS-1:0]   mode_reg, mode_next;
    logic [VERTEX_BITS-1:0] vtx_reg, vtx_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [VERTEX_BITS-1:0] cur_v_reg, cur_v_next;
    logic [KEY_BITS-1:0]    cur_k_reg, cur_k_next;
    logic [VERTEX_BITS-1:0] child_v_reg, child_v_next;
    logic [KEY_BITS-1:0]    child_k_reg, child_k_next;
    logic [VERTEX_BITS-1:0] res_v_reg, res_v_next;
    logic [KEY_BITS-1:0]    res_k_reg, res_k_next;
    imh_status_t            status_reg, status_next;
    logic                   down_reg, down_next;
    logic                   moved_reg, moved_next;
    logic [VERTEX_BITS-1:0] clr_reg, clr_next;
    logic                   out_valid_reg, out_valid_next;
    imh_out_t               out_data_reg, out_data_next;

    // Memory ports.
    logic [SB-1:0]          slot_raddr;
    logic                   slot_we;
    logic [SB-1:0]          slot_waddr;
    logic [VERTEX_BITS-1:0] slot_wv;
    logic [KEY_BITS-1:0]    slot_wk;
    logic [VERTEX_BITS-1:0] rd_v_reg;
    logic [KEY_BITS-1:0]    rd_k_reg;

    logic [VERTEX_BITS-1:0] vmap_raddr;
    logic                   vslot_we;
    logic [VERTEX_BITS-1:0] vslot_waddr;
    logic [SB-1:0]          vslot_wdata;
    logic [SB-1:0]          vslot_rd_reg;
    logic                   present_we;
    logic [VERTEX_BITS-1:0] present_waddr;
    logic                   present_wdata;
    logic                   present_rd_reg;

    // Derived indexes and compares.
    logic [SB:0]         left_idx;
    logic [SB:0]         right_idx;
    logic [SB:0]         cnt_wide;
    logic [SB-1:0]       parent_pos;
    logic [SB-1:0]       last_pos;
    logic                has_left;
    logic                has_right;
    logic [KEY_BITS-1:0] cmp_a;
    logic [KEY_BITS-1:0] cmp_b;
    logic                key_gt;
    logic                out_free;
    logic                item_xfer;

    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign cnt_wide   = (SB + 1)'(cnt_reg);
    assign parent_pos = SB'((pos_reg - 1'b1) >> 1);
    assign last_pos   = SB'(cnt_reg - 1'b1);
    assign has_left   = left_idx < cnt_wide;
    assign has_right  = right_idx < cnt_wide;

    // The one shared comparator: its operand pair is picked by state; compares are signed.
    // Sift up weighs the moving entry against its parent, the right child is weighed against
    // the left one, and sift down weighs the moving entry against the chosen child.
    assign cmp_a  = (state_reg == ST_DN_R) ? rd_k_reg : cur_k_reg;
    assign cmp_b  = (state_reg == ST_UP_CMP) ? rd_k_reg : child_k_reg;
    assign key_gt = $signed(cmp_a) > $signed(cmp_b);

    assign out_free  = !out_valid_reg || result.ready;
    assign item_xfer = item.valid && item.ready;

    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == VERTEX_BITS'(VERTEX_SPACE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                unique case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (present_rd_reg || cnt_reg >= CB'(CAPACITY))
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_UP_RD;
                        end
                    end
                    MODE_REMOVE_MAX:
                    begin
                        state_next = (cnt_reg == '0) ? ST_FINISH : ST_TAIL;
                    end
                    MODE_REMOVE_VTX:
                    begin
                        if (!present_rd_reg || CB'(vslot_rd_reg) >= cnt_reg)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_FETCH:
            begin
                state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                state_next = (tgt_pos_reg == last_pos) ? ST_FINISH : ST_UP_RD;
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = (down_reg && !moved_reg) ? ST_DN_RD : ST_PLACE;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (key_gt)
                begin
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = (down_reg && !moved_reg) ? ST_DN_RD : ST_PLACE;
                end
            end
            ST_DN_RD:
            begin
                state_next = has_left ? ST_DN_L : ST_PLACE;
            end
            ST_DN_L:
            begin
                state_next = has_right ? ST_DN_R : ST_DN_CMP;
            end
            ST_DN_R:
            begin
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                state_next = key_gt ? ST_PLACE : ST_DN_RD;
            end
            ST_PLACE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: datapath controls and register updates.
    always_comb
    begin
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        tgt_pos_next   = tgt_pos_reg;
        child_pos_next = child_pos_reg;
        mode_next      = mode_reg;
        vtx_next       = vtx_reg;
        key_next       = key_reg;
        cur_v_next     = cur_v_reg;
        cur_k_next     = cur_k_reg;
        child_v_next   = child_v_reg;
        child_k_next   = child_k_reg;
        res_v_next     = res_v_reg;
        res_k_next     = res_k_reg;
        status_next    = status_reg;
        down_next      = down_reg;
        moved_next     = moved_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;

        slot_raddr    = '0;
        slot_we       = 1'b0;
        slot_waddr    = pos_reg;
        slot_wv       = cur_v_reg;
        slot_wk       = cur_k_reg;
        vmap_raddr    = item.data.vertex;
        vslot_we      = 1'b0;
        vslot_waddr   = cur_v_reg;
        vslot_wdata   = pos_reg;
        present_we    = 1'b0;
        present_waddr = vtx_reg;
        present_wdata = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                present_we    = 1'b1;
                present_waddr = clr_reg;
                present_wdata = 1'b0;
                clr_next      = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                // Bitmap, map and root are read while waiting for an operation.
                slot_raddr = '0;
                if (item_xfer)
                begin
                    mode_next = item.data.mode;
                    vtx_next  = item.data.vertex;
                    key_next  = KEY_BITS'($unsigned(item.data.key));
                end
            end
            ST_CHECK:
            begin
                res_v_next  = '0;
                res_k_next  = '0;
                status_next = STATUS_OK;
                down_next   = 1'b0;
                moved_next  = 1'b0;
                unique case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (present_rd_reg)
                        begin
                            status_next = STATUS_PRESENT;
                        end
                        else if (cnt_reg >= CB'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            present_we    = 1'b1;
                            present_waddr = vtx_reg;
                            present_wdata = 1'b1;
                            cur_v_next    = vtx_reg;
                            cur_k_next    = key_reg;
                            pos_next      = SB'(cnt_reg);
                            cnt_next      = cnt_reg + 1'b1;
                        end
                    end
                    MODE_REMOVE_MAX:
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            res_v_next   = rd_v_reg;
                            res_k_next   = rd_k_reg;
                            tgt_pos_next = '0;
                            slot_raddr   = last_pos;
                        end
                    end
                    MODE_REMOVE_VTX:
                    begin
                        if (!present_rd_reg || CB'(vslot_rd_reg) >= cnt_reg)
                        begin
                            status_next = STATUS_ABSENT;
                        end
                        else
                        begin
                            tgt_pos_next = vslot_rd_reg;
                            slot_raddr   = vslot_rd_reg;
                        end
                    end
                    default:
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            res_v_next = rd_v_reg;
                            res_k_next = rd_k_reg;
                        end
                    end
                endcase
            end
            ST_FETCH:
            begin
                res_v_next = rd_v_reg;
                res_k_next = rd_k_reg;
                slot_raddr = last_pos;
            end
            ST_TAIL:
            begin
                // The last entry fills the hole left by the removed one.
                cnt_next      = cnt_reg - 1'b1;
                present_we    = 1'b1;
                present_waddr = res_v_reg;
                present_wdata = 1'b0;
                cur_v_next    = rd_v_reg;
                cur_k_next    = rd_k_reg;
                pos_next      = tgt_pos_reg;
                down_next     = 1'b1;
            end
            ST_UP_RD:
            begin
                slot_raddr = parent_pos;
            end
            ST_UP_CMP:
            begin
                if (key_gt)
                begin
                    // Parent moves down into the hole.
                    slot_we     = 1'b1;
                    slot_waddr  = pos_reg;
                    slot_wv     = rd_v_reg;
                    slot_wk     = rd_k_reg;
                    vslot_we    = 1'b1;
                    vslot_waddr = rd_v_reg;
                    vslot_wdata = pos_reg;
                    pos_next    = parent_pos;
                    moved_next  = 1'b1;
                end
            end
            ST_DN_RD:
            begin
                slot_raddr = left_idx[SB-1:0];
            end
            ST_DN_L:
            begin
                child_v_next   = rd_v_reg;
                child_k_next   = rd_k_reg;
                child_pos_next = left_idx[SB-1:0];
                slot_raddr     = right_idx[SB-1:0];
            end
            ST_DN_R:
            begin
                // The right child wins only when strictly greater.
                if (key_gt)
                begin
                    child_v_next   = rd_v_reg;
                    child_k_next   = rd_k_reg;
                    child_pos_next = right_idx[SB-1:0];
                end
            end
            ST_DN_CMP:
            begin
                if (!key_gt)
                begin
                    // Equal keys still swap, so the child moves up.
                    slot_we     = 1'b1;
                    slot_waddr  = pos_reg;
                    slot_wv     = child_v_reg;
                    slot_wk     = child_k_reg;
                    vslot_we    = 1'b1;
                    vslot_waddr = child_v_reg;
                    vslot_wdata = pos_reg;
                    pos_next    = child_pos_reg;
                end
            end
            ST_PLACE:
            begin
                slot_we     = 1'b1;
                slot_waddr  = pos_reg;
                slot_wv     = cur_v_reg;
                slot_wk     = cur_k_reg;
                vslot_we    = 1'b1;
                vslot_waddr = cur_v_reg;
                vslot_wdata = pos_reg;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.out_vertex  = res_v_reg;
                    out_data_next.out_key     = OUT_KEY_BITS'($unsigned(res_k_reg));
                    out_data_next.count_after = COUNT_OUT_BITS'(cnt_reg);
                    out_data_next.status      = status_reg;
                end
            end
            default:
            begin
                slot_raddr = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        tgt_pos_reg   <= tgt_pos_next;
        child_pos_reg <= child_pos_next;
        mode_reg      <= mode_next;
        vtx_reg       <= vtx_next;
        key_reg       <= key_next;
        cur_v_reg     <= cur_v_next;
        cur_k_reg     <= cur_k_next;
        child_v_reg   <= child_v_next;
        child_k_reg   <= child_k_next;
        res_v_reg     <= res_v_next;
        res_k_reg     <= res_k_next;
        status_reg    <= status_next;
        down_reg      <= down_next;
        moved_reg     <= moved_next;
        out_data_reg  <= out_data_next;
    end

    // Slot memory.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_v_mem[slot_waddr] <= slot_wv;
            slot_k_mem[slot_waddr] <= slot_wk;
        end
        rd_v_reg <= slot_v_mem[slot_raddr];
        rd_k_reg <= slot_k_mem[slot_raddr];
    end

    // Position map.
    always_ff @(posedge clk)
    begin
        if (vslot_we)
        begin
            vslot_mem[vslot_waddr] <= vslot_wdata;
        end
        vslot_rd_reg <= vslot_mem[vmap_raddr];
    end

    // Presence bitmap.
    always_ff @(posedge clk)
    begin
        if (present_we)
        begin
            present_mem[present_waddr] <= present_wdata;
        end
        present_rd_reg <= present_mem[vmap_raddr];
    end

endmodule
